@@ src/mjg_pkg.sv @@
package mjg_pkg;

  // Default geometry limits of the image.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IMAGE_WIDTH = 1'b0;

  localparam int WIDTH_REG_W = 11;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;

  // Result field widths.
  localparam int COORD_W      = 10;
  localparam int ROW_WEIGHT_W = 11;

  typedef struct packed {
    logic [COORD_W-1:0]             node_row;
    logic [COORD_W-1:0]             node_col;
    logic                           first_node;
    logic                           row_link_valid;
    logic [COORD_W-1:0]             row_link_col;
    logic signed [ROW_WEIGHT_W-1:0] row_weight;
    logic                           col_link_valid;
    logic [COORD_W-1:0]             col_link_row;
    logic [COORD_W-1:0]             col_weight;
  } result_t;

endpackage

@@ src/mjg_row_mem.sv @@
module mjg_row_mem #(
  parameter int ADDR_W = $clog2(mjg_pkg::DEF_MAX_WIDTH) + 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic [ADDR_W-1:0] rd_a_addr,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic              rd_a_data,
  output logic              rd_b_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic mem [DEPTH];
  logic mem_a;
  logic mem_b;
  logic fwd_a;
  logic fwd_b;
  logic fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_a <= mem[rd_a_addr];
    mem_b <= mem[rd_b_addr];
  end

  // A write landing on an address read at the same edge is passed through.
  always_ff @(posedge clk) begin
    fwd_a    <= wr_en && (wr_addr == rd_a_addr);
    fwd_b    <= wr_en && (wr_addr == rd_b_addr);
    fwd_data <= wr_data;
  end

  assign rd_a_data = fwd_a ? fwd_data : mem_a;
  assign rd_b_data = fwd_b ? fwd_data : mem_b;

endmodule

@@ src/mjg_col_mem.sv @@
module mjg_col_mem #(
  parameter int ADDR_W = $clog2(mjg_pkg::DEF_MAX_WIDTH),
  parameter int DATA_W = $clog2(mjg_pkg::DEF_MAX_HEIGHT) + 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] fwd_data;
  logic              fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

@@ src/mjg_out_fifo.sv @@
module mjg_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mjg_pkg::result_t push_data,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output mjg_pkg::result_t head
);

  mjg_pkg::result_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic             pop_ok;

  assign valid  = count != 2'd0;
  assign full   = count == 2'd2;
  assign pop_ok = pop && valid;
  assign head   = slot[rd_ptr];

  always_comb begin
    case ({push, pop_ok})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/maze_junction_graph_builder_core.sv @@
// Maze junction graph builder.
// The input channel (in_valid / in_stall, fields cmd and pixel) takes a binary maze image
// in raster order, one pixel per transaction; cmd high marks a flush transaction that
// closes the final row. Each cell is judged one row late, when the pixel below it
// arrives, and every junction found leaves as one transaction on the output channel
// (out_valid / out_stall) with its position and its links to the nearest earlier nodes
// in its row and column. image_width is written through the APB port at byte address 0.
// Throughput is one input transaction per clock while in_stall is low: the neighbor bits
// and the column tracker are prefetched from their memories for the next scan position, so
// the only loop is the read-modify-write of the column tracker, closed by write forwarding.
// A junction's result is written into the result queue as its pixel is taken.
// A two-entry result queue separates the channels, so a stalled receiver holds input back
// only once two results are waiting.
// After reset the row store and the column tracker are cleared, one entry per cycle;
// in_stall stays high during that pass, while configuration writes are accepted as ever.
module maze_junction_graph_builder_core #(
  parameter int MAX_WIDTH  = mjg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mjg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mjg_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [mjg_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [mjg_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic                                   pixel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mjg_pkg::COORD_W-1:0]            node_row,
  output logic [mjg_pkg::COORD_W-1:0]            node_col,
  output logic                                   first_node,
  output logic                                   row_link_valid,
  output logic [mjg_pkg::COORD_W-1:0]            row_link_col,
  output logic signed [mjg_pkg::ROW_WEIGHT_W-1:0] row_weight,
  output logic                                   col_link_valid,
  output logic [mjg_pkg::COORD_W-1:0]            col_link_row,
  output logic [mjg_pkg::COORD_W-1:0]            col_weight
);

  localparam int COORD_W  = mjg_pkg::COORD_W;
  localparam int RWGT_W   = mjg_pkg::ROW_WEIGHT_W;
  localparam int WREG_W   = mjg_pkg::WIDTH_REG_W;
  localparam int DATA_W   = mjg_pkg::APB_DATA_W;
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_HEIGHT);
  localparam int SW       = $clog2(MAX_HEIGHT + 1);
  localparam int MW       = CW + 1;
  localparam int EW       = (CW + 1 > WREG_W + 1) ? CW + 1 : WREG_W + 1;
  localparam int DW       = (CW > RWGT_W) ? CW : RWGT_W;
  localparam int RDW      = (RW > COORD_W) ? RW : COORD_W;

  typedef enum logic [1:0] {
    PH_CLEAR = 2'b01,
    PH_RUN   = 2'b10
  } phase_t;

  phase_t phase;
  logic [MW-1:0] clr_cnt;
  logic          clearing;

  logic [WREG_W-1:0] image_width;

  logic [SW-1:0] scan_row, scan_row_next;
  logic [CW-1:0] scan_col, scan_col_next;
  logic          row_last_valid, row_last_valid_next;
  logic [CW-1:0] row_last_col, row_last_col_next;
  logic          head_seen, head_seen_next;
  logic          flushing, flushing_next;

  // Sliding window over the row being judged: self_bit is the cell at scan_col,
  // left_bit the one before it; first_bit keeps column 0 of the row last written.
  logic self_bit, self_bit_next;
  logic left_bit, left_bit_next;
  logic first_bit, first_bit_next;

  logic          accept;
  logic          advance;
  logic          judging;
  logic [EW-1:0] width_raw, width_eff, col_plus1;
  logic          last_col;
  logic          fl, bot, ending, wr_val;
  logic          top, right, left, self_open;
  logic          row_valid_eff;
  logic          junction;
  logic [RW-1:0] judged_row;

  logic          top_rd, right_rd;
  logic          row_wr_en, row_wr_data;
  logic [MW-1:0] row_wr_addr, row_rd_top, row_rd_right;

  logic          col_wr_en;
  logic [CW-1:0] col_wr_addr;
  logic [RW:0]   col_wr_data, col_rd_data;
  logic          col_valid_rd;
  logic [RW-1:0] col_row_rd;

  mjg_pkg::result_t result, head;
  logic             push, fifo_full;

  // Clearing pass after reset.
  assign clearing = phase == PH_CLEAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (phase)
        PH_CLEAR: begin
          clr_cnt <= clr_cnt + MW'(1);
          if (clr_cnt == '1) begin
            phase <= PH_RUN;
          end
        end
        PH_RUN: begin
          phase <= PH_RUN;
        end
        default: begin
          phase <= PH_CLEAR;
        end
      endcase
    end
  end

  // Configuration register; the word index is the upper address bit.
  assign pready = 1'b1;
  assign prdata = (paddr[mjg_pkg::APB_ADDR_W-1] == mjg_pkg::REG_IMAGE_WIDTH) ?
                  DATA_W'(image_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= mjg_pkg::WIDTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[mjg_pkg::APB_ADDR_W-1] == mjg_pkg::REG_IMAGE_WIDTH) begin
      image_width <= pwdata[WREG_W-1:0];
    end
  end

  // Effective width: zero acts as one, anything above MAX_WIDTH as MAX_WIDTH.
  always_comb begin
    width_raw = EW'(image_width);
    if (width_raw == '0) begin
      width_eff = EW'(1);
    end else if (width_raw > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
  end

  assign col_plus1 = EW'(scan_col) + EW'(1);
  assign last_col  = col_plus1 >= width_eff;

  assign in_stall = clearing || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign judging  = scan_row != '0;
  // While row 0 is arriving a flush transaction changes nothing.
  assign advance  = accept && (judging || !cmd);

  // Once a flush starts inside a row, the rest of that row acts as flush.
  assign fl         = cmd || flushing;
  assign bot        = !fl && pixel;
  assign ending     = fl || (scan_row >= SW'(MAX_HEIGHT));
  assign wr_val     = judging ? bot : pixel;
  assign judged_row = RW'(scan_row - SW'(1));

  // Neighbors outside the image are wall.
  assign top       = (scan_row != SW'(1)) && top_rd;
  assign right     = !last_col && right_rd;
  assign left      = (scan_col != '0) && left_bit;
  assign self_open = self_bit;

  assign row_valid_eff = (scan_col != '0) && row_last_valid;

  assign junction = self_open &&
                    ((left != right) || (top != bot) || (top && bot && left && right));

  assign col_valid_rd = col_rd_data[RW];
  assign col_row_rd   = col_rd_data[RW-1:0];

  always_comb begin
    scan_row_next       = scan_row;
    scan_col_next       = scan_col;
    row_last_valid_next = row_last_valid;
    row_last_col_next   = row_last_col;
    head_seen_next      = head_seen;
    flushing_next       = flushing;
    self_bit_next       = self_bit;
    left_bit_next       = left_bit;
    first_bit_next      = first_bit;
    if (advance) begin
      if (judging) begin
        row_last_valid_next = row_valid_eff;
        if (!self_open) begin
          row_last_valid_next = 1'b0;
        end else if (junction) begin
          row_last_valid_next = 1'b1;
          row_last_col_next   = scan_col;
          head_seen_next      = 1'b1;
        end
        flushing_next = fl;
      end
      if (scan_col == '0) begin
        first_bit_next = wr_val;
      end
      if (last_col) begin
        scan_col_next = '0;
        left_bit_next = 1'b0;
        // Column 0 of the next row to judge is the row just written.
        self_bit_next = (scan_col == '0) ? wr_val : first_bit;
        if (!judging) begin
          scan_row_next = SW'(1);
        end else if (ending) begin
          scan_row_next  = '0;
          flushing_next  = 1'b0;
          head_seen_next = 1'b0;
        end else begin
          scan_row_next = scan_row + SW'(1);
        end
      end else begin
        scan_col_next = scan_col + CW'(1);
        left_bit_next = self_bit;
        self_bit_next = right_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row       <= '0;
      scan_col       <= '0;
      row_last_valid <= 1'b0;
      row_last_col   <= '0;
      head_seen      <= 1'b0;
      flushing       <= 1'b0;
    end else begin
      scan_row       <= scan_row_next;
      scan_col       <= scan_col_next;
      row_last_valid <= row_last_valid_next;
      row_last_col   <= row_last_col_next;
      head_seen      <= head_seen_next;
      flushing       <= flushing_next;
    end
  end

  always_ff @(posedge clk) begin
    self_bit  <= self_bit_next;
    left_bit  <= left_bit_next;
    first_bit <= first_bit_next;
  end

  // Row store: two row halves selected by row parity. The bottom pixel overwrites the
  // row above the judged one, and reads are issued for the next scan position.
  assign row_wr_en    = clearing || advance;
  assign row_wr_addr  = clearing ? clr_cnt : {scan_row[0], scan_col};
  assign row_wr_data  = !clearing && wr_val;
  assign row_rd_top   = {scan_row_next[0], scan_col_next};
  assign row_rd_right = {~scan_row_next[0], scan_col_next + CW'(1)};

  mjg_row_mem #(
    .ADDR_W (MW)
  ) u_row_mem (
    .clk       (clk),
    .wr_en     (row_wr_en),
    .wr_addr   (row_wr_addr),
    .wr_data   (row_wr_data),
    .rd_a_addr (row_rd_top),
    .rd_b_addr (row_rd_right),
    .rd_a_data (top_rd),
    .rd_b_data (right_rd)
  );

  // Column tracker: a wall or the image end invalidates it, a junction takes it over.
  assign col_wr_en   = clearing ||
                       (advance && judging && (!self_open || junction || ending));
  assign col_wr_addr = clearing ? clr_cnt[CW-1:0] : scan_col;
  assign col_wr_data = clearing ? '0 : {junction && !ending, judged_row};

  mjg_col_mem #(
    .ADDR_W (CW),
    .DATA_W (RW + 1)
  ) u_col_mem (
    .clk     (clk),
    .wr_en   (col_wr_en),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_addr (scan_col_next),
    .rd_data (col_rd_data)
  );

  always_comb begin
    result.node_row       = COORD_W'(judged_row);
    result.node_col       = COORD_W'(scan_col);
    result.first_node     = !head_seen;
    result.row_link_valid = row_valid_eff;
    result.row_link_col   = row_valid_eff ? COORD_W'(row_last_col) : '0;
    result.row_weight     = row_valid_eff ?
                            RWGT_W'(DW'(row_last_col) - DW'(scan_col)) : '0;
    result.col_link_valid = col_valid_rd;
    result.col_link_row   = col_valid_rd ? COORD_W'(col_row_rd) : '0;
    result.col_weight     = col_valid_rd ?
                            COORD_W'(RDW'(judged_row) - RDW'(col_row_rd)) : '0;
  end

  assign push = advance && judging && junction;

  mjg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (!out_stall),
    .valid     (out_valid),
    .full      (fifo_full),
    .head      (head)
  );

  assign node_row       = head.node_row;
  assign node_col       = head.node_col;
  assign first_node     = head.first_node;
  assign row_link_valid = head.row_link_valid;
  assign row_link_col   = head.row_link_col;
  assign row_weight     = head.row_weight;
  assign col_link_valid = head.col_link_valid;
  assign col_link_row   = head.col_link_row;
  assign col_weight     = head.col_weight;

endmodule

@@ src/mjg_checker.sv @@
module mjg_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [mjg_pkg::COORD_W-1:0]            node_row,
  input logic [mjg_pkg::COORD_W-1:0]            node_col,
  input logic                                   first_node,
  input logic                                   row_link_valid,
  input logic [mjg_pkg::COORD_W-1:0]            row_link_col,
  input logic signed [mjg_pkg::ROW_WEIGHT_W-1:0] row_weight,
  input logic                                   col_link_valid,
  input logic [mjg_pkg::COORD_W-1:0]            col_link_row,
  input logic [mjg_pkg::COORD_W-1:0]            col_weight
);

  // The memory clearing pass holds input back right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during the clearing pass");

  // Missing links carry zero position and weight.
  a_unlinked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_link_valid || (row_link_col == '0 && row_weight == '0)) &&
                  (col_link_valid || (col_link_row == '0 && col_weight == '0)))
    else $error("unlinked result carries a nonzero link field");

  // A row link never points to the node's own column: its weight is nonzero.
  a_row_link_left: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_link_valid |-> row_weight != '0)
    else $error("row link with zero weight");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_row) && $stable(node_col) &&
                               $stable(first_node) && $stable(row_weight) &&
                               $stable(col_weight))
    else $error("stalled result changed");

endmodule

bind maze_junction_graph_builder_core mjg_checker u_mjg_checker (.*);
